>>> hw/rtl/checksummed_frame_deframer_unit_macros.svh
// Assertion helpers shared by the deframer modules.
`ifndef CHECKSUMMED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define CHECKSUMMED_FRAME_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CFDU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfdu assertion failed");
// next-cycle implication
`define CFDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfdu assertion failed");
`else
`define CFDU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CFDU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/cfdu_pkg.sv
package cfdu_pkg;

    localparam int CFDU_QUEUE_DEPTH = 4;

    localparam logic [7:0] CFDU_HUNT_LIMIT_RST = 8'd40;
    localparam logic [7:0] CFDU_HOST_TFI_RST   = 8'hD5;

    localparam logic CFG_IDX_HUNT_LIMIT = 1'b0;
    localparam logic CFG_IDX_HOST_TFI   = 1'b1;

    // classified transaction as it travels from front to back
    typedef struct packed {
        logic       is_arm;
        logic [7:0] rx_byte;
        logic       is_zero;
        logic       is_ff;
        logic       is_7f;
        logic       is_81;
    } t_item;

endpackage

>>> hw/rtl/cfdu_front.sv
`include "checksummed_frame_deframer_unit_macros.svh"

module cfdu_front
    import cfdu_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFDU_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_item            w_item;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_item.is_arm  = ~i_kind;
        w_item.rx_byte = i_rx_byte;
        w_item.is_zero = (i_rx_byte == 8'h00);
        w_item.is_ff   = (i_rx_byte == 8'hFF);
        w_item.is_7f   = (i_rx_byte == 8'h7F);
        w_item.is_81   = (i_rx_byte == 8'h81);
    end

    assign o_in_stall = (r_count == CNT_FULL);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    `CFDU_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_push, r_count < CNT_FULL)
    `CFDU_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_q_pop && o_q_valid, r_count != '0)
    `CFDU_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + CNT_W'(1))

endmodule

>>> hw/rtl/cfdu_back.sv
`include "checksummed_frame_deframer_unit_macros.svh"

module cfdu_back
    import cfdu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_hunt_limit,
    input  logic [7:0]  i_host_tfi,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_payload_length,
    output logic        o_postamble_bad
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HUNT    = 4'd1;
    localparam logic [3:0] PH_LEN     = 4'd2;
    localparam logic [3:0] PH_LCS     = 4'd3;
    localparam logic [3:0] PH_EXT_M   = 4'd4;
    localparam logic [3:0] PH_EXT_L   = 4'd5;
    localparam logic [3:0] PH_EXT_LCS = 4'd6;
    localparam logic [3:0] PH_TFI     = 4'd7;
    localparam logic [3:0] PH_DATA    = 4'd8;
    localparam logic [3:0] PH_DCS     = 4'd9;
    localparam logic [3:0] PH_POST    = 4'd10;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_ERRFRAME = 2'd3;

    localparam logic OUT_PAYLOAD = 1'b0;
    localparam logic OUT_STATUS  = 1'b1;

    logic [3:0]  r_phase, n_phase;
    logic        r_z_old, n_z_old;   // byte two back was zero
    logic        r_z_new, n_z_new;   // previous byte was zero
    logic [7:0]  r_hunt_count, n_hunt_count;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_data_sum, n_data_sum;
    logic [7:0]  r_length_high, n_length_high;
    logic        r_tfi_7f, n_tfi_7f;
    logic        r_id_ok, n_id_ok;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_payload_byte;
    logic [1:0]  r_status;
    logic [15:0] r_payload_length;
    logic        r_postamble_bad;

    logic        w_pop;
    logic        w_emit;
    logic        w_emit_kind;
    logic [7:0]  w_emit_byte;
    logic [1:0]  w_emit_status;
    logic [15:0] w_emit_length;
    logic        w_emit_pbad;

    logic [7:0]  w_b;
    logic [7:0]  w_hc_next;
    logic [7:0]  w_lim;
    logic [7:0]  w_sum_lcs;
    logic [7:0]  w_sum_ext;
    logic [7:0]  w_sum_dcs;
    logic [15:0] w_left_dec;
    logic [15:0] w_start_len;

    assign w_pop   = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = w_pop;

    assign w_b        = i_q_item.rx_byte;
    assign w_hc_next  = (r_hunt_count != 8'hFF) ? r_hunt_count + 8'd1 : r_hunt_count;
    assign w_lim      = (i_hunt_limit < 8'd3) ? 8'd3 : i_hunt_limit;
    assign w_sum_lcs  = r_length_high + w_b;
    assign w_sum_ext  = r_length_high + r_frame_length[7:0] + w_b;
    assign w_sum_dcs  = r_data_sum + w_b;
    assign w_left_dec = r_bytes_left - 16'd1;
    assign w_start_len = (r_phase == PH_LCS) ? {8'h00, r_length_high} : r_frame_length;

    always_comb begin
        n_phase        = r_phase;
        n_z_old        = r_z_old;
        n_z_new        = r_z_new;
        n_hunt_count   = r_hunt_count;
        n_frame_length = r_frame_length;
        n_bytes_left   = r_bytes_left;
        n_data_sum     = r_data_sum;
        n_length_high  = r_length_high;
        n_tfi_7f       = r_tfi_7f;
        n_id_ok        = r_id_ok;
        w_emit         = 1'b0;
        w_emit_kind    = OUT_STATUS;
        w_emit_byte    = 8'h00;
        w_emit_status  = ST_OK;
        w_emit_length  = 16'h0000;
        w_emit_pbad    = 1'b0;

        if (w_pop) begin
            if (i_q_item.is_arm) begin
                n_phase        = PH_HUNT;
                n_z_old        = 1'b1;
                n_z_new        = 1'b1;
                n_hunt_count   = 8'h00;
                n_frame_length = 16'h0000;
                n_bytes_left   = 16'h0000;
                n_data_sum     = 8'h00;
                n_length_high  = 8'h00;
                n_tfi_7f       = 1'b0;
                n_id_ok        = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        n_hunt_count = w_hc_next;
                        if (w_hc_next >= 8'd3 && r_z_old && r_z_new && i_q_item.is_ff) begin
                            n_phase = PH_LEN;
                        end else begin
                            n_z_old = r_z_new;
                            n_z_new = i_q_item.is_zero;
                            if (w_hc_next >= w_lim) begin
                                w_emit        = 1'b1;
                                w_emit_status = ST_INVALID;
                            end
                        end
                    end
                    PH_LEN: begin
                        n_length_high = w_b;
                        n_phase       = PH_LCS;
                    end
                    PH_LCS, PH_EXT_LCS: begin
                        if (r_phase == PH_LCS && r_length_high == 8'hFF && i_q_item.is_ff) begin
                            n_phase = PH_EXT_M;
                        end else if ((r_phase == PH_LCS ? w_sum_lcs : w_sum_ext) != 8'h00) begin
                            w_emit        = 1'b1;
                            w_emit_status = ST_CHECKSUM;
                        end else if (w_start_len == 16'h0000) begin
                            w_emit        = 1'b1;
                            w_emit_status = ST_INVALID;
                        end else begin
                            n_frame_length = w_start_len;
                            n_bytes_left   = w_start_len;
                            n_data_sum     = 8'h00;
                            n_phase        = PH_TFI;
                        end
                    end
                    PH_EXT_M: begin
                        n_length_high = w_b;
                        n_phase       = PH_EXT_L;
                    end
                    PH_EXT_L: begin
                        n_frame_length = {r_length_high, w_b};
                        n_phase        = PH_EXT_LCS;
                    end
                    PH_TFI: begin
                        n_tfi_7f     = i_q_item.is_7f;
                        n_id_ok      = (w_b == i_host_tfi);
                        n_data_sum   = w_b;
                        n_bytes_left = w_left_dec;
                        n_phase      = (w_left_dec == 16'h0000) ? PH_DCS : PH_DATA;
                    end
                    PH_DATA: begin
                        n_data_sum   = w_sum_dcs;
                        n_bytes_left = w_left_dec;
                        if (w_left_dec == 16'h0000) begin
                            n_phase = PH_DCS;
                        end
                        if (r_id_ok) begin
                            w_emit      = 1'b1;
                            w_emit_kind = OUT_PAYLOAD;
                            w_emit_byte = w_b;
                        end
                    end
                    PH_DCS: begin
                        w_emit = 1'b1;
                        if (r_frame_length == 16'd1 && r_tfi_7f && i_q_item.is_81) begin
                            w_emit_status = ST_ERRFRAME;
                        end else if (!r_id_ok) begin
                            w_emit_status = ST_INVALID;
                        end else if (w_sum_dcs != 8'h00) begin
                            w_emit_status = ST_CHECKSUM;
                        end else begin
                            w_emit  = 1'b0;
                            n_phase = PH_POST;
                        end
                    end
                    PH_POST: begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_OK;
                        w_emit_length = r_frame_length - 16'd1;
                        w_emit_pbad   = !i_q_item.is_zero;
                    end
                    default: begin
                        // idle and unused codes: bytes are dropped
                        n_phase = PH_IDLE;
                    end
                endcase
                if (w_emit && w_emit_kind == OUT_STATUS) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_z_old        <= 1'b1;
            r_z_new        <= 1'b1;
            r_hunt_count   <= 8'h00;
            r_frame_length <= 16'h0000;
            r_bytes_left   <= 16'h0000;
            r_data_sum     <= 8'h00;
            r_length_high  <= 8'h00;
            r_tfi_7f       <= 1'b0;
            r_id_ok        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_z_old        <= n_z_old;
            r_z_new        <= n_z_new;
            r_hunt_count   <= n_hunt_count;
            r_frame_length <= n_frame_length;
            r_bytes_left   <= n_bytes_left;
            r_data_sum     <= n_data_sum;
            r_length_high  <= n_length_high;
            r_tfi_7f       <= n_tfi_7f;
            r_id_ok        <= n_id_ok;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind       <= w_emit_kind;
            r_payload_byte   <= w_emit_byte;
            r_status         <= w_emit_status;
            r_payload_length <= w_emit_length;
            r_postamble_bad  <= w_emit_pbad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out_kind;
    assign o_payload_byte   = r_payload_byte;
    assign o_status         = r_status;
    assign o_payload_length = r_payload_length;
    assign o_postamble_bad  = r_postamble_bad;

    `CFDU_ASSERT_NOW(a_no_pop_held, i_clk, i_rst_n, r_out_valid && i_out_stall, !w_pop)
    `CFDU_ASSERT_NOW(a_data_left, i_clk, i_rst_n, r_phase == PH_DATA, r_bytes_left != 16'h0000)
    `CFDU_ASSERT_NEXT(a_status_idles, i_clk, i_rst_n, w_emit && w_emit_kind == OUT_STATUS, r_phase == PH_IDLE)

endmodule

>>> hw/rtl/checksummed_frame_deframer_unit.sv
// Path: an input transaction is written into the queue, and the parser then steps it
// from the queue into the output register. Throughput, set by the single-step parser
// reading the queue: one transaction per cycle while the output is not stalled.
// A queue of QUEUE_DEPTH entries lets input and output stall independently.
// Reset (i_rst_n low, synchronous): parser idle and unarmed, queue and output empty,
// hunt_limit = 40, host_tfi = 0xD5. No clearing pass is needed.
module checksummed_frame_deframer_unit
    import cfdu_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFDU_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_payload_length,
    output logic        o_postamble_bad
);

    logic [7:0] r_hunt_limit;
    logic [7:0] r_host_tfi;
    logic       w_q_valid;
    t_item      w_q_item;
    logic       w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt_limit <= CFDU_HUNT_LIMIT_RST;
            r_host_tfi   <= CFDU_HOST_TFI_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IDX_HUNT_LIMIT: r_hunt_limit <= i_cfg_wdata;
                CFG_IDX_HOST_TFI:   r_host_tfi   <= i_cfg_wdata;
            endcase
        end
    end

    cfdu_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    cfdu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_hunt_limit     (r_hunt_limit),
        .i_host_tfi       (r_host_tfi),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_payload_byte   (o_payload_byte),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_postamble_bad  (o_postamble_bad)
    );

endmodule

>>> test/tb.sv
module tb;
    import cfdu_pkg::*;

    localparam logic KIND_ARM  = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    localparam logic OUT_PAYLOAD = 1'b0;
    localparam logic OUT_STATUS  = 1'b1;

    localparam logic [1:0] FS_OK          = 2'd0;
    localparam logic [1:0] FS_INVALID     = 2'd1;
    localparam logic [1:0] FS_CHECKSUM    = 2'd2;
    localparam logic [1:0] FS_ERROR_FRAME = 2'd3;

    localparam logic [7:0] START_CODE = 8'hFF;
    localparam logic [7:0] EXT_MARK   = 8'hFF;
    localparam logic [7:0] ERR_TFI    = 8'h7F;
    localparam logic [7:0] ERR_DCS    = 8'h81;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int QUIET_CYCLES   = CFDU_QUEUE_DEPTH + 8;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HUNT, PH_LEN, PH_LCS, PH_EXT_M, PH_EXT_L, PH_EXT_LCS,
        PH_TFI, PH_DATA, PH_DCS, PH_POST
    } t_parse_phase;

    typedef enum int {
        RSP_GOOD, RSP_BAD_LCS, RSP_ZERO_LEN, RSP_ERROR_FRAME, RSP_WRONG_TFI,
        RSP_BAD_DCS, RSP_ABANDON, RSP_NO_START, RSP_JUNK
    } t_response;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [15:0] payload_length;
        logic        postamble_bad;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_status;
    logic [15:0] o_payload_length;
    logic        o_postamble_bad;

    checksummed_frame_deframer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_kind       (o_out_kind),
        .o_payload_byte   (o_payload_byte),
        .o_status         (o_status),
        .o_payload_length (o_payload_length),
        .o_postamble_bad  (o_postamble_bad)
    );

    always #4 i_clk = ~i_clk;

    t_rx_item      rx_pending[$];
    t_frame_result frame_expect[$];
    t_frame_result want_res;

    int n_queued = 0;
    int n_taken = 0;
    int n_fail = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int pat_mode = 0;
    int pat_left = 0;
    int idle_cycles = 0;
    bit long_hold_done = 1'b0;

    // deframer state as the block should hold it
    logic [7:0]   hunt_limit_cfg = CFDU_HUNT_LIMIT_RST;
    logic [7:0]   host_tfi_cfg = CFDU_HOST_TFI_RST;
    t_parse_phase ph = PH_IDLE;
    logic [15:0]  tail_bytes = 16'h0000;
    logic [7:0]   hunt_cnt = 8'h00;
    logic [15:0]  frame_len = 16'h0000;
    logic [15:0]  bytes_left = 16'h0000;
    logic [7:0]   data_sum = 8'h00;
    logic [7:0]   len_hi = 8'h00;
    logic [7:0]   tfi_seen = 8'h00;
    logic         tfi_match = 1'b0;

    function automatic t_frame_result status_of(input logic [1:0] st, input logic [15:0] plen,
                                                input logic pbad);
        t_frame_result r;
        r = '0;
        r.out_kind = OUT_STATUS;
        r.status = st;
        r.payload_length = plen;
        r.postamble_bad = pbad;
        return r;
    endfunction

    task automatic predict_deframe(input logic kind, input logic [7:0] b);
        t_frame_result r;
        logic          emit;
        logic          open_data;
        logic [7:0]    lim;
        logic [7:0]    s8;
        logic [15:0]   new_len;
        r = '0;
        emit = 1'b0;
        open_data = 1'b0;
        new_len = 16'h0000;
        if (kind == KIND_ARM) begin
            ph = PH_HUNT;
            tail_bytes = 16'h0000;
            hunt_cnt = 8'h00;
            frame_len = 16'h0000;
            bytes_left = 16'h0000;
            data_sum = 8'h00;
            len_hi = 8'h00;
            tfi_seen = 8'h00;
            tfi_match = 1'b0;
        end else begin
            case (ph)
                PH_HUNT: begin
                    if (hunt_cnt != 8'd255)
                        hunt_cnt = hunt_cnt + 8'd1;
                    if (hunt_cnt >= 8'd3 && tail_bytes == 16'h0000 && b == START_CODE) begin
                        ph = PH_LEN;
                    end else begin
                        tail_bytes = {tail_bytes[7:0], b};
                        lim = (hunt_limit_cfg < 8'd3) ? 8'd3 : hunt_limit_cfg;
                        if (hunt_cnt >= lim) begin
                            r = status_of(FS_INVALID, 16'h0000, 1'b0);
                            emit = 1'b1;
                        end
                    end
                end
                PH_LEN: begin
                    len_hi = b;
                    ph = PH_LCS;
                end
                PH_LCS: begin
                    s8 = len_hi + b;
                    if (len_hi == EXT_MARK && b == EXT_MARK) begin
                        ph = PH_EXT_M;
                    end else if (s8 != 8'h00) begin
                        r = status_of(FS_CHECKSUM, 16'h0000, 1'b0);
                        emit = 1'b1;
                    end else begin
                        new_len = {8'h00, len_hi};
                        open_data = 1'b1;
                    end
                end
                PH_EXT_M: begin
                    len_hi = b;
                    ph = PH_EXT_L;
                end
                PH_EXT_L: begin
                    frame_len = {len_hi, b};
                    ph = PH_EXT_LCS;
                end
                PH_EXT_LCS: begin
                    s8 = len_hi + frame_len[7:0] + b;
                    if (s8 != 8'h00) begin
                        r = status_of(FS_CHECKSUM, 16'h0000, 1'b0);
                        emit = 1'b1;
                    end else begin
                        new_len = frame_len;
                        open_data = 1'b1;
                    end
                end
                PH_TFI: begin
                    tfi_seen = b;
                    tfi_match = (b == host_tfi_cfg);
                    data_sum = b;
                    bytes_left = bytes_left - 16'd1;
                    ph = (bytes_left == 16'h0000) ? PH_DCS : PH_DATA;
                end
                PH_DATA: begin
                    data_sum = data_sum + b;
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'h0000)
                        ph = PH_DCS;
                    if (tfi_match) begin
                        r.out_kind = OUT_PAYLOAD;
                        r.payload_byte = b;
                        emit = 1'b1;
                    end
                end
                PH_DCS: begin
                    s8 = data_sum + b;
                    if (frame_len == 16'd1 && tfi_seen == ERR_TFI && b == ERR_DCS)
                        r = status_of(FS_ERROR_FRAME, 16'h0000, 1'b0);
                    else if (!tfi_match)
                        r = status_of(FS_INVALID, 16'h0000, 1'b0);
                    else if (s8 != 8'h00)
                        r = status_of(FS_CHECKSUM, 16'h0000, 1'b0);
                    else
                        ph = PH_POST;
                    emit = (ph != PH_POST);
                end
                PH_POST: begin
                    r = status_of(FS_OK, frame_len - 16'd1, b != 8'h00);
                    emit = 1'b1;
                end
                default: begin
                    ph = PH_IDLE;
                end
            endcase
            if (open_data) begin
                if (new_len == 16'h0000) begin
                    r = status_of(FS_INVALID, 16'h0000, 1'b0);
                    emit = 1'b1;
                end else begin
                    frame_len = new_len;
                    bytes_left = new_len;
                    data_sum = 8'h00;
                    ph = PH_TFI;
                end
            end
        end
        if (emit) begin
            if (r.out_kind == OUT_STATUS)
                ph = PH_IDLE;
            frame_expect.insert(frame_expect.size(), r);
        end
    endtask

    task automatic push_rx(input logic kind, input logic [7:0] b);
        t_rx_item it;
        it.kind = kind;
        it.rx_byte = b;
        rx_pending.insert(rx_pending.size(), it);
        n_queued++;
    endtask

    task automatic queue_response(input t_response mode, input int len, input bit ext);
        int         lim;
        int         lead;
        int         cut;
        int         i;
        logic [7:0] lcs;
        logic [7:0] tfi;
        logic [7:0] sum;
        logic [7:0] b;
        lim = (hunt_limit_cfg < 8'd3) ? 3 : int'(hunt_limit_cfg);
        if (mode == RSP_JUNK) begin
            repeat ($urandom_range(1, 6))
                push_rx($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
            return;
        end
        // byte value on an arm is don't-care
        push_rx(KIND_ARM, 8'($urandom_range(0, 255)));
        if (mode == RSP_NO_START) begin
            // no 00 or FF, so the start code can never form
            repeat (lim) push_rx(KIND_BYTE, 8'($urandom_range(1, 254)));
            return;
        end
        lead = $urandom_range(0, (lim - 3 < 5) ? lim - 3 : 5);
        repeat (lead) push_rx(KIND_BYTE, 8'($urandom_range(0, 255)));
        push_rx(KIND_BYTE, 8'h00);
        push_rx(KIND_BYTE, 8'h00);
        push_rx(KIND_BYTE, START_CODE);
        if (mode == RSP_ERROR_FRAME) begin
            push_rx(KIND_BYTE, 8'h01);
            push_rx(KIND_BYTE, 8'hFF);
            push_rx(KIND_BYTE, ERR_TFI);
            push_rx(KIND_BYTE, ERR_DCS);
            return;
        end
        if (mode == RSP_ZERO_LEN)
            len = 0;
        if (ext) begin
            push_rx(KIND_BYTE, EXT_MARK);
            push_rx(KIND_BYTE, EXT_MARK);
            push_rx(KIND_BYTE, len[15:8]);
            push_rx(KIND_BYTE, len[7:0]);
            lcs = 8'h00 - len[15:8] - len[7:0];
        end else begin
            push_rx(KIND_BYTE, len[7:0]);
            lcs = 8'h00 - len[7:0];
        end
        if (mode == RSP_BAD_LCS)
            lcs = lcs + 8'($urandom_range(1, 255));
        push_rx(KIND_BYTE, lcs);
        if (mode == RSP_BAD_LCS || mode == RSP_ZERO_LEN)
            return;
        tfi = host_tfi_cfg;
        if (mode == RSP_WRONG_TFI)
            tfi = tfi ^ 8'($urandom_range(1, 255));
        push_rx(KIND_BYTE, tfi);
        sum = tfi;
        if (mode == RSP_ABANDON)
            cut = $urandom_range(0, (len - 1 < 10) ? len - 1 : 10);
        else
            cut = len - 1;
        for (i = 0; i < cut; i++) begin
            b = 8'($urandom_range(0, 255));
            push_rx(KIND_BYTE, b);
            sum = sum + b;
        end
        // an abandoned frame is cut off by the next arm
        if (mode == RSP_ABANDON)
            return;
        b = 8'h00 - sum;
        if (mode == RSP_BAD_DCS)
            b = b + 8'($urandom_range(1, 255));
        push_rx(KIND_BYTE, b);
        push_rx(KIND_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
    endtask

    task automatic queue_random_response();
        int        pick;
        int        sz;
        int        len;
        t_response mode;
        pick = $urandom_range(0, 99);
        sz = $urandom_range(0, 99);
        if (sz < 70)
            len = $urandom_range(1, 8);
        else if (sz < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 300);
        if (pick < 55)
            mode = RSP_GOOD;
        else if (pick < 62)
            mode = RSP_BAD_LCS;
        else if (pick < 67)
            mode = RSP_ZERO_LEN;
        else if (pick < 72)
            mode = RSP_ERROR_FRAME;
        else if (pick < 79)
            mode = RSP_WRONG_TFI;
        else if (pick < 86)
            mode = RSP_BAD_DCS;
        else if (pick < 91)
            mode = RSP_ABANDON;
        else if (pick < 95)
            mode = RSP_NO_START;
        else
            mode = RSP_JUNK;
        queue_response(mode, len, len > 255 || $urandom_range(0, 4) == 0);
    endtask

    task automatic queue_random_items(input int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at)
            queue_random_response();
    endtask

    task automatic wait_quiet();
        while (rx_pending.size() != 0 || frame_expect.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_IDX_HUNT_LIMIT)
            hunt_limit_cfg = val;
        else
            host_tfi_cfg = val;
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_deframe(i_kind, i_rx_byte);
                void'(rx_pending.pop_front());
                n_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_kind <= rx_pending[0].kind;
                    i_rx_byte <= rx_pending[0].rx_byte;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result, stalls on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frame_expect.size() == 0) begin
                    $error("unexpected result: out_kind %0d payload_byte %0h status %0d",
                           o_out_kind, o_payload_byte, o_status);
                    n_fail++;
                end else begin
                    want_res = frame_expect.pop_front();
                    if (o_out_kind !== want_res.out_kind) begin
                        $error("out_kind: expected %0d, got %0d", want_res.out_kind, o_out_kind);
                        n_fail++;
                    end
                    if (o_payload_byte !== want_res.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want_res.payload_byte, o_payload_byte);
                        n_fail++;
                    end
                    if (o_status !== want_res.status) begin
                        $error("status: expected %0d, got %0d", want_res.status, o_status);
                        n_fail++;
                    end
                    if (o_payload_length !== want_res.payload_length) begin
                        $error("payload_length: expected %0d, got %0d",
                               want_res.payload_length, o_payload_length);
                        n_fail++;
                    end
                    if (o_postamble_bad !== want_res.postamble_bad) begin
                        $error("postamble_bad: expected %0d, got %0d",
                               want_res.postamble_bad, o_postamble_bad);
                        n_fail++;
                    end
                end
            end
            // one long hold-off while plenty is pending, so the block backs up
            if (hold_left == 0 && !long_hold_done && rx_pending.size() >= 40) begin
                hold_left = 100;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && $urandom_range(0, 499) == 0) begin
                hold_left = $urandom_range(30, 90);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(8, 64);
                end
                pat_left--;
                case (pat_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= 1'($urandom_range(0, 1));
                    2: i_out_stall <= (pat_left % 3 == 0);
                    default: i_out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL checksummed_frame_deframer_unit");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] dcs;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_rx(KIND_BYTE, 8'hA5);  // ignored while unarmed
        queue_response(RSP_ERROR_FRAME, 1, 1'b0);
        queue_response(RSP_ZERO_LEN, 0, 1'b0);
        queue_response(RSP_BAD_LCS, 3, 1'b0);
        queue_response(RSP_GOOD, 1, 1'b0);
        queue_response(RSP_GOOD, 3, 1'b1);
        // frame stays open across a host_tfi change; the TFI match is latched
        push_rx(KIND_ARM, 8'h00);
        push_rx(KIND_BYTE, 8'h00);
        push_rx(KIND_BYTE, 8'h00);
        push_rx(KIND_BYTE, START_CODE);
        push_rx(KIND_BYTE, 8'h03);
        push_rx(KIND_BYTE, 8'hFD);
        push_rx(KIND_BYTE, CFDU_HOST_TFI_RST);
        push_rx(KIND_BYTE, 8'h5A);
        wait_quiet();

        write_reg(CFG_IDX_HUNT_LIMIT, 8'd3);
        write_reg(CFG_IDX_HOST_TFI, 8'h00);
        dcs = 8'h00 - CFDU_HOST_TFI_RST - 8'h5A - 8'h3C;
        push_rx(KIND_BYTE, 8'h3C);
        push_rx(KIND_BYTE, dcs);
        push_rx(KIND_BYTE, 8'h00);
        queue_response(RSP_NO_START, 0, 1'b0);
        queue_response(RSP_WRONG_TFI, 4, 1'b0);
        queue_response(RSP_BAD_DCS, 2, 1'b0);
        queue_random_items(20);
        wait_quiet();

        write_reg(CFG_IDX_HUNT_LIMIT, 8'd255);
        write_reg(CFG_IDX_HOST_TFI, 8'hFF);
        queue_response(RSP_NO_START, 0, 1'b0);
        queue_response(RSP_ABANDON, 255, 1'b0);
        queue_response(RSP_ABANDON, 65535, 1'b1);
        queue_response(RSP_BAD_LCS, 300, 1'b1);
        queue_response(RSP_ZERO_LEN, 0, 1'b1);
        queue_random_items(20);
        wait_quiet();

        // below the minimum, acts as three
        write_reg(CFG_IDX_HUNT_LIMIT, 8'd0);
        write_reg(CFG_IDX_HOST_TFI, 8'($urandom_range(0, 255)));
        queue_response(RSP_NO_START, 0, 1'b0);
        queue_random_items(20);

        repeat (4) begin
            wait_quiet();
            write_reg(CFG_IDX_HUNT_LIMIT, 8'($urandom_range(3, 40)));
            write_reg(CFG_IDX_HOST_TFI,
                      ($urandom_range(0, 1) == 0) ? CFDU_HOST_TFI_RST
                                                  : 8'($urandom_range(0, 255)));
            queue_random_items(10);
        end
        wait_quiet();

        if (n_fail == 0 && frame_expect.size() == 0)
            $display("PASS checksummed_frame_deframer_unit");
        else
            $display("FAIL checksummed_frame_deframer_unit");
        $finish;
    end

endmodule
